FILE: sv/bmp_pkg.sv
`timescale 1ns / 1ps
package bmp_pkg;

   localparam int unsigned HdrLast   = 53;
   localparam int unsigned MagicIdx  = 1;
   localparam int unsigned WidthLo   = 18;
   localparam int unsigned WidthHi   = 21;
   localparam int unsigned HeightLo  = 22;
   localparam int unsigned HeightHi  = 25;
   localparam logic [7:0]  MagicB    = 8'h42;
   localparam logic [7:0]  MagicM    = 8'h4d;
   localparam logic [12:0] SizeSat   = 13'h1fff;

   typedef enum logic [1:0] {
      KIND_PIXEL     = 2'd0,
      KIND_SIZES     = 2'd1,
      KIND_NOT_BMP   = 2'd2,
      KIND_TOO_LARGE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] column;
      logic [11:0] row;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        last;
   } rsp_type;

   function automatic logic [12:0] sat13(input logic [31:0] v);
      logic [12:0] r;
      r = (v > 32'(SizeSat)) ? SizeSat : v[12:0];
      return r;
   endfunction

endpackage

FILE: sv/bmp_parse_core.sv
`timescale 1ns / 1ps
module bmp_parse_core #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             file_start,
   output logic             res_valid,
   output bmp_pkg::rsp_type res
);
   import bmp_pkg::*;

   localparam int unsigned CntW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [31:0] MaxDimW = 32'(MAX_DIM);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PIXEL,
      PH_PAD,
      PH_DONE,
      PH_ERROR
   } phase_type;

   phase_type        phase_ff, phase_in, ph;
   logic [5:0]       idx_ff, idx_in, idx;
   logic [31:0]      w_ff, w_in, w_cur;
   logic [31:0]      h_ff, h_in, h_cur;
   logic [CntW-1:0]  col_ff, col_in;
   logic [CntW-1:0]  row_ff, row_in;
   logic [1:0]       bip_ff, bip_in;
   logic [7:0]       blue_ff, blue_in;
   logic [7:0]       green_ff, green_in;
   logic [1:0]       pad_ff, pad_in;
   logic [CntW:0]    col_plus, row_plus;
   logic [CntW+11:0] col_ext, row_ext;
   logic [5:0]       lane_w, lane_h;

   always_comb begin
      ph    = file_start ? PH_HEADER : phase_ff;
      idx   = file_start ? 6'd0 : idx_ff;
      w_cur = file_start ? 32'd0 : w_ff;
      h_cur = file_start ? 32'd0 : h_ff;

      col_plus = {1'b0, col_ff} + {{CntW{1'b0}}, 1'b1};
      row_plus = {1'b0, row_ff} + {{CntW{1'b0}}, 1'b1};
      col_ext  = {12'd0, col_ff};
      row_ext  = {12'd0, row_ff};
      lane_w   = idx - 6'(WidthLo);
      lane_h   = idx - 6'(HeightLo);

      phase_in = ph;
      idx_in   = idx;
      w_in     = w_cur;
      h_in     = h_cur;
      col_in   = col_ff;
      row_in   = row_ff;
      bip_in   = bip_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      pad_in   = pad_ff;

      res_valid = 1'b0;
      res       = '0;

      unique case (ph)
         PH_HEADER: begin
            if (idx == 6'd0) begin
               blue_in = data_byte;
            end else if (idx == 6'(MagicIdx)
                         && (blue_ff != MagicB || data_byte != MagicM)) begin
               phase_in  = PH_ERROR;
               res_valid = 1'b1;
               res.kind  = KIND_NOT_BMP;
            end else if (idx >= 6'(WidthLo) && idx <= 6'(WidthHi)) begin
               w_in = w_cur | (32'(data_byte) << {lane_w[1:0], 3'b000});
            end else if (idx >= 6'(HeightLo) && idx <= 6'(HeightHi)) begin
               h_in = h_cur | (32'(data_byte) << {lane_h[1:0], 3'b000});
            end
            if (!res_valid) begin
               if (idx != 6'(HdrLast)) begin
                  idx_in = idx + 6'd1;
               end else begin
                  idx_in           = 6'd0;
                  res_valid        = 1'b1;
                  res.image_width  = sat13(w_cur);
                  res.image_height = sat13(h_cur);
                  if (w_cur > MaxDimW || h_cur > MaxDimW) begin
                     phase_in = PH_ERROR;
                     res.kind = KIND_TOO_LARGE;
                  end else begin
                     res.kind = KIND_SIZES;
                     if (w_cur == 32'd0 || h_cur == 32'd0) begin
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_PIXEL;
                        col_in   = '0;
                        row_in   = '0;
                        bip_in   = 2'd0;
                     end
                  end
               end
            end
         end
         PH_PIXEL: begin
            if (bip_ff == 2'd0) begin
               blue_in = data_byte;
               bip_in  = 2'd1;
            end else if (bip_ff == 2'd1) begin
               green_in = data_byte;
               bip_in   = 2'd2;
            end else begin
               bip_in     = 2'd0;
               res_valid  = 1'b1;
               res.kind   = KIND_PIXEL;
               res.red    = data_byte;
               res.green  = green_ff;
               res.blue   = blue_ff;
               res.column = col_ext[11:0];
               res.row    = row_ext[11:0];
               if (32'(col_plus) < w_ff) begin
                  col_in = col_plus[CntW-1:0];
               end else begin
                  col_in = '0;
                  if (32'(row_plus) >= h_ff) begin
                     res.last = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     row_in = row_plus[CntW-1:0];
                     pad_in = w_ff[1:0];
                     if (w_ff[1:0] != 2'd0) begin
                        phase_in = PH_PAD;
                     end
                  end
               end
            end
         end
         PH_PAD: begin
            pad_in = pad_ff - 2'd1;
            if (pad_ff == 2'd1) begin
               phase_in = PH_PIXEL;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         idx_ff   <= '0;
         w_ff     <= '0;
         h_ff     <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         bip_ff   <= '0;
         blue_ff  <= '0;
         green_ff <= '0;
         pad_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         bip_ff   <= bip_in;
         blue_ff  <= blue_in;
         green_ff <= green_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

FILE: sv/bmp_out_skid.sv
`timescale 1ns / 1ps
module bmp_out_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bmp_pkg::rsp_type push_data,
   output logic             space,
   output logic             out_valid,
   input  logic             out_ready,
   output bmp_pkg::rsp_type out_data
);
   import bmp_pkg::*;

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_ff, skid_ff;
   logic    pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_ff       <= push_data;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= push_data;
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         main_valid_ff <= 1'b0;
      end
   end

endmodule

FILE: sv/bmp_pixel_stream_parser.sv
`timescale 1ns / 1ps
// channel  direction  ports
// req      in         req_valid req_ready req_data_byte req_file_start
// rsp      out        rsp_valid rsp_ready rsp_kind rsp_red rsp_green rsp_blue
//                     rsp_column rsp_row rsp_image_width rsp_image_height rsp_last
//
// one byte accepted per cycle while req_ready is high; the parser state updates in
// the accepting cycle and any result lands in a two-entry output buffer in the
// cycle after; req_ready drops only while both output entries are full
// synchronous reset returns the parser to the file header; no clearing pass
module bmp_pixel_stream_parser #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [11:0] rsp_column,
   output logic [11:0] rsp_row,
   output logic [12:0] rsp_image_width,
   output logic [12:0] rsp_image_height,
   output logic        rsp_last
);
   import bmp_pkg::*;

   logic    fire, res_valid, space;
   rsp_type res, out_data;

   assign req_ready = space;
   assign fire      = req_valid && space;

   bmp_parse_core #(
      .MAX_DIM(MAX_DIM)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (fire),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .res_valid  (res_valid),
      .res        (res)
   );

   bmp_out_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && res_valid),
      .push_data (res),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_kind         = out_data.kind;
   assign rsp_red          = out_data.red;
   assign rsp_green        = out_data.green;
   assign rsp_blue         = out_data.blue;
   assign rsp_column       = out_data.column;
   assign rsp_row          = out_data.row;
   assign rsp_image_width  = out_data.image_width;
   assign rsp_image_height = out_data.image_height;
   assign rsp_last         = out_data.last;

endmodule
